// ===== rtl/mvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants of the matrix vector transform
// Word layouts, coefficient and product widths, register indexes.
// ----------------------------------------------------------------------------
package mvt_pkg;

    // Matrix order and field widths
    localparam int ROWS        = 4;
    localparam int COEF_W      = 16;
    localparam int COMP_W      = 32;
    localparam int ROW_W       = ROWS * COEF_W;
    localparam int FRAC_SHIFT  = 12;

    // Product of one Q4.12 coefficient and one Q16.16 component
    localparam int PROD_W      = COEF_W + COMP_W;
    // Sum of two products, then of four
    localparam int PAIR_W      = PROD_W + 1;
    localparam int ACC_W       = PROD_W + 2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3 = 2'd3;

    // Q4.12 one, placed on the diagonal at reset
    localparam logic [COEF_W-1:0] COEF_ONE = 16'h1000;

    // Saturation limits of a Q16.16 result
    localparam logic [COMP_W-1:0] OUT_MAX = 32'h7fff_ffff;
    localparam logic [COMP_W-1:0] OUT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [COMP_W-1:0] in_x;
        logic signed [COMP_W-1:0] in_y;
        logic signed [COMP_W-1:0] in_z;
        logic signed [COMP_W-1:0] in_w;
    } in_word_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
        logic                     saturated;
    } out_word_t;

    // One row's finished result as it leaves a lane
    typedef struct packed {
        logic signed [COMP_W-1:0] value;
        logic                     clip;
    } lane_res_t;

endpackage

// ===== rtl/matrix_vector_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_transform: 4x4 fixed-point matrix times vector stream
// Four Q16.16 components in, four saturated Q16.16 row products out.
// ----------------------------------------------------------------------------
// The block takes one vector word per clock and returns one result word per
// clock while out_ready stays high. Each matrix row has its own lane of four
// 16x32 multipliers followed by a registered adder tree, so all sixteen
// products of a vector are formed in the same cycle; a word passes the
// product, pair and result registers of its lane, then the output register.
// When the output word is not taken, the whole pipeline holds and in_ready
// drops. Rows and columns from DIM upward are unused and their outputs read
// zero. The matrix resets to the identity; rewrite rows only while no word
// is in flight.
// ----------------------------------------------------------------------------
module matrix_vector_transform #(
    parameter int DIM = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mvt_pkg::in_word_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mvt_pkg::out_word_t                out_data,
    input  logic                              wr_en,
    input  logic [mvt_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [mvt_pkg::ROW_W-1:0]         wr_data
);

    localparam int STAGES = 3;

    logic [mvt_pkg::ROW_W-1:0]          matrix_reg [mvt_pkg::ROWS];
    logic [STAGES-1:0]                  valid_reg;
    logic                               en;
    logic signed [mvt_pkg::COMP_W-1:0]  vec [mvt_pkg::ROWS];
    mvt_pkg::lane_res_t                 res [mvt_pkg::ROWS];

    // Pipeline advances unless a finished word is waiting
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign vec[0] = in_data.in_x;
    assign vec[1] = in_data.in_y;
    assign vec[2] = in_data.in_z;
    assign vec[3] = in_data.in_w;

    // Matrix rows, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mvt_pkg::ROWS; i++)
            begin
                matrix_reg[i] <= mvt_pkg::ROW_W'(mvt_pkg::COEF_ONE) << (mvt_pkg::COEF_W * i);
            end
        end
        else if (wr_en)
        begin
            case (wr_index)
                mvt_pkg::REG_ROW0: matrix_reg[0] <= wr_data;
                mvt_pkg::REG_ROW1: matrix_reg[1] <= wr_data;
                mvt_pkg::REG_ROW2: matrix_reg[2] <= wr_data;
                mvt_pkg::REG_ROW3: matrix_reg[3] <= wr_data;
                default: ;
            endcase
        end
    end

    // Track which lane stages hold a word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // One lane per used row; unused rows read zero
    for (genvar i = 0; i < mvt_pkg::ROWS; i++)
    begin : g_row
        if (i < DIM)
        begin : g_lane
            mvt_lane #(
                .DIM   (DIM)
            ) u_lane (
                .clk   (clk),
                .en    (en),
                .coefs (matrix_reg[i]),
                .vec   (vec),
                .res   (res[i])
            );
        end
        else
        begin : g_unused
            assign res[i] = '0;
        end
    end

    mvt_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .lane_valid (valid_reg[STAGES-1]),
        .res        (res),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    // An accepted word enters the first lane stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
    else $error("accepted word did not enter the lanes");

    // A word leaving the last lane stage reaches the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        en && valid_reg[STAGES-1] |=> out_valid)
    else $error("word lost between lanes and output");

    // A waiting output word stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output is stalled");

    // A clip flag implies some component sits at a limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            (out_data.out_x == mvt_pkg::OUT_MAX) || (out_data.out_x == mvt_pkg::OUT_MIN) ||
            (out_data.out_y == mvt_pkg::OUT_MAX) || (out_data.out_y == mvt_pkg::OUT_MIN) ||
            (out_data.out_z == mvt_pkg::OUT_MAX) || (out_data.out_z == mvt_pkg::OUT_MIN) ||
            (out_data.out_w == mvt_pkg::OUT_MAX) || (out_data.out_w == mvt_pkg::OUT_MIN))
    else $error("saturated flag without a clipped component");

    // Row 3 (out_w) stays zero when DIM leaves it unused
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DIM > 3) || (out_data.out_w == '0))
    else $error("unused row produced a nonzero value");

endmodule

// ===== rtl/mvt_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_lane: one matrix row dot product
// Four multipliers, a two-level adder tree, floor shift and saturation,
// registered after each level. Columns from DIM upward contribute zero.
// ----------------------------------------------------------------------------
module mvt_lane #(
    parameter int DIM = 4
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [mvt_pkg::ROW_W-1:0]            coefs,
    input  logic signed [mvt_pkg::COMP_W-1:0]    vec [mvt_pkg::ROWS],
    output mvt_pkg::lane_res_t                   res
);

    localparam int SHIFT_W = mvt_pkg::ACC_W - mvt_pkg::FRAC_SHIFT;

    logic signed [mvt_pkg::PROD_W-1:0] coef_ext  [mvt_pkg::ROWS];
    logic signed [mvt_pkg::PROD_W-1:0] vec_ext   [mvt_pkg::ROWS];
    logic signed [mvt_pkg::PROD_W-1:0] prod_next [mvt_pkg::ROWS];
    logic signed [mvt_pkg::PROD_W-1:0] prod_reg  [mvt_pkg::ROWS];
    logic signed [mvt_pkg::PAIR_W-1:0] pair_next [2];
    logic signed [mvt_pkg::PAIR_W-1:0] pair_reg  [2];
    logic signed [mvt_pkg::ACC_W-1:0]  acc;
    logic signed [mvt_pkg::ACC_W-1:0]  acc_shift;
    logic signed [SHIFT_W-1:0]         scaled;
    logic                              fits;
    mvt_pkg::lane_res_t                res_next;
    mvt_pkg::lane_res_t                res_reg;

    // Multiply each coefficient by its component; drop unused columns
    always_comb
    begin
        for (int j = 0; j < mvt_pkg::ROWS; j++)
        begin
            coef_ext[j] = mvt_pkg::PROD_W'(
                signed'(coefs[mvt_pkg::COEF_W*j +: mvt_pkg::COEF_W]));
            vec_ext[j]  = mvt_pkg::PROD_W'(vec[j]);
            if (j < DIM)
            begin
                prod_next[j] = coef_ext[j] * vec_ext[j];
            end
            else
            begin
                prod_next[j] = '0;
            end
        end
    end

    // Add products in pairs
    always_comb
    begin
        pair_next[0] = mvt_pkg::PAIR_W'(prod_reg[0]) + mvt_pkg::PAIR_W'(prod_reg[1]);
        pair_next[1] = mvt_pkg::PAIR_W'(prod_reg[2]) + mvt_pkg::PAIR_W'(prod_reg[3]);
    end

    // Final sum, floor shift back to Q16.16, clip to 32 bits
    always_comb
    begin
        acc       = mvt_pkg::ACC_W'(pair_reg[0]) + mvt_pkg::ACC_W'(pair_reg[1]);
        acc_shift = acc >>> mvt_pkg::FRAC_SHIFT;
        scaled    = acc_shift[SHIFT_W-1:0];
        fits      = (&scaled[SHIFT_W-1:mvt_pkg::COMP_W-1])
                 || (~|scaled[SHIFT_W-1:mvt_pkg::COMP_W-1]);
        res_next.clip = !fits;
        if (fits)
        begin
            res_next.value = scaled[mvt_pkg::COMP_W-1:0];
        end
        else if (scaled[SHIFT_W-1])
        begin
            res_next.value = mvt_pkg::OUT_MIN;
        end
        else
        begin
            res_next.value = mvt_pkg::OUT_MAX;
        end
    end

    // Advance the lane pipeline whenever the block is not stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            pair_reg <= pair_next;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/mvt_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_merge: combine the row lanes into one result word
// Packs the four row results, ORs the clip flags and holds the output
// register with its valid bit.
// ----------------------------------------------------------------------------
module mvt_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 lane_valid,
    input  mvt_pkg::lane_res_t   res [mvt_pkg::ROWS],
    output logic                 out_valid,
    output mvt_pkg::out_word_t   out_data
);

    mvt_pkg::out_word_t out_data_next;
    mvt_pkg::out_word_t out_data_reg;
    logic               out_valid_reg;

    // Pack row results and flag any clipped component
    always_comb
    begin
        out_data_next.out_x     = res[0].value;
        out_data_next.out_y     = res[1].value;
        out_data_next.out_z     = res[2].value;
        out_data_next.out_w     = res[3].value;
        out_data_next.saturated = res[0].clip | res[1].clip | res[2].clip | res[3].clip;
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= lane_valid;
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/mvt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_checker: result predictor and scoreboard for matrix_vector_transform
// Tracks the matrix rows through the write port, computes the transformed
// vector for every accepted input word and compares each output word with
// the oldest prediction.
// ----------------------------------------------------------------------------
module mvt_checker #(
    parameter int DIM = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  mvt_pkg::in_word_t                   in_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  mvt_pkg::out_word_t                  out_data,
    input  logic                                wr_en,
    input  logic [mvt_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [mvt_pkg::ROW_W-1:0]           wr_data,
    output int                                  miscompares,
    output int                                  in_flight
);

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam int     REPORT_MAX = 10;

    logic [mvt_pkg::ROW_W-1:0] coef_rows [mvt_pkg::ROWS];
    mvt_pkg::out_word_t        pending_results [$];
    int                        bad_count = 0;
    int                        pending_count = 0;

    assign miscompares = bad_count;
    assign in_flight   = pending_count;

    // Matrix times vector: exact sum, floor shift back to Q16.16, clip to 32 bits
    function automatic mvt_pkg::out_word_t transform_vec(input mvt_pkg::in_word_t v);
        longint                            comp [mvt_pkg::ROWS];
        longint                            acc;
        longint                            shifted;
        longint                            coef;
        logic signed [mvt_pkg::COMP_W-1:0] res [mvt_pkg::ROWS];
        logic                              clip;
        mvt_pkg::out_word_t                o;
        int                                i;
        int                                j;
        comp[0] = v.in_x;
        comp[1] = v.in_y;
        comp[2] = v.in_z;
        comp[3] = v.in_w;
        clip = 1'b0;
        for (i = 0; i < mvt_pkg::ROWS; i++)
        begin
            res[i] = '0;
            if (i < DIM)
            begin
                acc = 0;
                for (j = 0; j < DIM; j++)
                begin
                    coef = longint'($signed(
                        coef_rows[i][mvt_pkg::COEF_W*j +: mvt_pkg::COEF_W]));
                    acc += coef * comp[j];
                end
                shifted = acc >>> mvt_pkg::FRAC_SHIFT;
                if (shifted > SAT_HI)
                begin
                    res[i] = mvt_pkg::OUT_MAX;
                    clip   = 1'b1;
                end
                else if (shifted < SAT_LO)
                begin
                    res[i] = mvt_pkg::OUT_MIN;
                    clip   = 1'b1;
                end
                else
                begin
                    res[i] = shifted[mvt_pkg::COMP_W-1:0];
                end
            end
        end
        o.out_x     = res[0];
        o.out_y     = res[1];
        o.out_z     = res[2];
        o.out_w     = res[3];
        o.saturated = clip;
        return o;
    endfunction

    // Track writes, predict on input words, compare on output words
    always @(posedge clk or negedge rst_n)
    begin
        mvt_pkg::out_word_t want;
        if (!rst_n)
        begin
            coef_rows[0] = mvt_pkg::ROW_W'(mvt_pkg::COEF_ONE);
            coef_rows[1] = mvt_pkg::ROW_W'(mvt_pkg::COEF_ONE) << mvt_pkg::COEF_W;
            coef_rows[2] = mvt_pkg::ROW_W'(mvt_pkg::COEF_ONE) << (2 * mvt_pkg::COEF_W);
            coef_rows[3] = mvt_pkg::ROW_W'(mvt_pkg::COEF_ONE) << (3 * mvt_pkg::COEF_W);
            pending_results.delete();
            pending_count = 0;
        end
        else
        begin
            // Check the oldest prediction against the word leaving the block
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (bad_count < REPORT_MAX)
                        $display("%0t: result word with nothing pending: %s",
                                 $realtime,
                                 $sformatf("x=%h y=%h z=%h w=%h sat=%b",
                                           out_data.out_x, out_data.out_y,
                                           out_data.out_z, out_data.out_w,
                                           out_data.saturated));
                    bad_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
                        out_data.out_z !== want.out_z || out_data.out_w !== want.out_w ||
                        out_data.saturated !== want.saturated)
                    begin
                        if (bad_count < REPORT_MAX)
                        begin
                            $display("%0t: mismatch expected x=%h y=%h z=%h w=%h sat=%b",
                                     $realtime, want.out_x, want.out_y, want.out_z,
                                     want.out_w, want.saturated);
                            $display("%0t:               got x=%h y=%h z=%h w=%h sat=%b",
                                     $realtime, out_data.out_x, out_data.out_y,
                                     out_data.out_z, out_data.out_w, out_data.saturated);
                        end
                        bad_count++;
                    end
                end
            end

            // Predict from the matrix in place when the vector is taken
            if (in_valid && in_ready)
                pending_results.push_back(transform_vec(in_data));

            pending_count = pending_results.size();

            // Update the matrix copy
            if (wr_en)
                coef_rows[wr_index] = wr_data;
        end
    end

endmodule

// ===== tb/matrix_vector_transform_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_transform_tb: stimulus and verdict for the matrix transform
// Drives directed corner vectors and matrices, then phases of random vectors
// under a range of matrices, with random idle gaps on both channels. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module matrix_vector_transform_tb;

    localparam int DIM          = 4;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 175;
    // Run length limit, chosen with a wide margin over the worst case
    localparam int CYCLE_LIMIT  = 300000;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    mvt_pkg::in_word_t                   in_data   = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    mvt_pkg::out_word_t                  out_data;
    logic                                wr_en     = 1'b0;
    logic [mvt_pkg::CFG_INDEX_W-1:0]     wr_index  = mvt_pkg::REG_ROW0;
    logic [mvt_pkg::ROW_W-1:0]           wr_data   = '0;

    int                                  miscompares;
    int                                  in_flight;
    int                                  cycles    = 0;
    bit                                  in_calm   = 1'b0;
    bit                                  out_calm  = 1'b0;

    matrix_vector_transform #(
        .DIM(DIM)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    mvt_checker #(
        .DIM(DIM)
    ) i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .miscompares(miscompares),
        .in_flight  (in_flight)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL matrix_vector_transform");
            $finish;
        end
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic mvt_pkg::in_word_t vec4(
        input logic [mvt_pkg::COMP_W-1:0] x, input logic [mvt_pkg::COMP_W-1:0] y,
        input logic [mvt_pkg::COMP_W-1:0] z, input logic [mvt_pkg::COMP_W-1:0] w);
        mvt_pkg::in_word_t v;
        v.in_x = x;
        v.in_y = y;
        v.in_z = z;
        v.in_w = w;
        return v;
    endfunction

    // Mix of extremes, full-range and small components
    function automatic logic [mvt_pkg::COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0:       return mvt_pkg::OUT_MAX;
            1:       return mvt_pkg::OUT_MIN;
            2, 3, 4: return $urandom();
            default: return $urandom_range(0, 32'h1f_ffff) - 32'h10_0000;
        endcase
    endfunction

    function automatic logic [mvt_pkg::ROW_W-1:0] rand_row(input bit narrow);
        logic [mvt_pkg::ROW_W-1:0] r;
        int                        j;
        if (!narrow)
            return {$urandom(), $urandom()};
        r = '0;
        for (j = 0; j < mvt_pkg::ROWS; j++)
            r[mvt_pkg::COEF_W*j +: mvt_pkg::COEF_W] =
                mvt_pkg::COEF_W'($urandom_range(0, 16'h2000) - 16'h1000);
        return r;
    endfunction

    // Offer one vector word and hold it until taken
    task automatic send_vec(input mvt_pkg::in_word_t v);
        int gap;
        gap = draw_gap(in_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop sending and wait until every predicted word has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [mvt_pkg::CFG_INDEX_W-1:0] index,
                             input logic [mvt_pkg::ROW_W-1:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic write_matrix(input logic [mvt_pkg::ROW_W-1:0] r0,
                                input logic [mvt_pkg::ROW_W-1:0] r1,
                                input logic [mvt_pkg::ROW_W-1:0] r2,
                                input logic [mvt_pkg::ROW_W-1:0] r3);
        write_reg(mvt_pkg::REG_ROW0, r0);
        write_reg(mvt_pkg::REG_ROW1, r1);
        write_reg(mvt_pkg::REG_ROW2, r2);
        write_reg(mvt_pkg::REG_ROW3, r3);
    endtask

    // Receiver: hold out_ready low for a random gap before each word
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(out_calm);
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [mvt_pkg::ROW_W-1:0] rows [mvt_pkg::ROWS];
        int                        kind;
        int                        p;
        int                        k;
        int                        i;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Identity after reset: vectors pass straight through
        send_vec(vec4('0, '0, '0, '0));
        send_vec(vec4(mvt_pkg::OUT_MAX, mvt_pkg::OUT_MAX, mvt_pkg::OUT_MAX, mvt_pkg::OUT_MAX));
        send_vec(vec4(mvt_pkg::OUT_MIN, mvt_pkg::OUT_MIN, mvt_pkg::OUT_MIN, mvt_pkg::OUT_MIN));
        send_vec(vec4(mvt_pkg::OUT_MAX, mvt_pkg::OUT_MIN, 32'hffff_ffff, 32'h0000_0001));
        send_vec(vec4(32'haaaa_aaaa, 32'h5555_5555, 32'h0001_0000, 32'hffff_0000));
        send_vec(vec4(32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0001, 32'h7fff_fffe));
        drain();

        // Extreme coefficients: clip high and low, floor rounding of small negatives
        write_matrix({4{16'h7fff}}, {4{16'h8000}}, {4{16'h0001}},
                     {16'hffff, 16'h0001, 16'h8000, 16'h7fff});
        send_vec(vec4(mvt_pkg::OUT_MAX, mvt_pkg::OUT_MAX, mvt_pkg::OUT_MAX, mvt_pkg::OUT_MAX));
        send_vec(vec4(mvt_pkg::OUT_MIN, mvt_pkg::OUT_MIN, mvt_pkg::OUT_MIN, mvt_pkg::OUT_MIN));
        send_vec(vec4(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_vec(vec4(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_vec(vec4(mvt_pkg::OUT_MAX, mvt_pkg::OUT_MIN, '0, 32'hffff_ffff));
        send_vec(vec4(mvt_pkg::OUT_MIN, mvt_pkg::OUT_MAX, 32'hffff_ffff, 32'h0000_0001));
        send_vec(vec4(32'h0000_0fff, 32'hffff_f001, 32'h0000_1000, 32'hffff_f000));
        send_vec(vec4(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0000_8000));
        drain();

        // Random phases over a range of matrices
        for (p = 0; p < PHASES; p++)
        begin
            kind = (p < 6) ? p : int'($urandom_range(0, 1));
            for (i = 0; i < mvt_pkg::ROWS; i++)
            begin
                case (kind)
                    0:       rows[i] = rand_row(1'b0);
                    1:       rows[i] = rand_row(1'b1);
                    2:       rows[i] = {4{16'h7fff}};
                    3:       rows[i] = {4{16'h8000}};
                    4:       rows[i] = '0;
                    default: rows[i] = mvt_pkg::ROW_W'(mvt_pkg::COEF_ONE) << (mvt_pkg::COEF_W * i);
                endcase
            end
            write_matrix(rows[0], rows[1], rows[2], rows[3]);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // Redraw pacing now and then so both busy and idle stretches occur
                if (k % 50 == 0)
                begin
                    in_calm  = ($urandom_range(0, 3) == 0);
                    out_calm = ($urandom_range(0, 3) == 0);
                end
                send_vec(vec4(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
            end
            drain();
        end

        if (miscompares == 0 && in_flight == 0)
            $display("PASS matrix_vector_transform");
        else
            $display("FAIL matrix_vector_transform");
        $finish;
    end

endmodule
